>>> rtl/sbh_pkg.sv
// Shared types, constants and round functions of the SHA-1 byte stream hasher.
package sbh_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB  = 2'd0,
    OP_DIGEST  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  localparam int unsigned NumHashWords = 5;
  localparam int unsigned NumRounds    = 80;
  localparam int unsigned BlockWords   = 16;
  localparam logic [2:0]  LastWordIdx  = 3'd4;

  localparam logic [31:0] InitHash [NumHashWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

>>> rtl/sbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sbh_front.sv
// Input side: accept words, drop unused op codes, queue commands for the engine.
module sbh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [1:0]          s_op_i,
  input  logic [7:0]          s_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output sbh_pkg::cmd_t       cmd_o
);
  import sbh_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, known_op;

  assign s_ready_o   = (cnt_q != 2'd2);
  assign known_op    = (s_op_i == OP_ABSORB) || (s_op_i == OP_DIGEST) ||
                       (s_op_i == OP_RESTART);
  assign push        = s_valid_i && s_ready_o && known_op;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{op: op_e'(s_op_i), data: s_data_i};
    end
  end

endmodule

>>> rtl/sbh_core.sv
// Hash engine: byte packing, block store, 80-round compression and digest output.
module sbh_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  sbh_pkg::cmd_t       cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_word_o,
  output logic [2:0]          out_idx_o,
  output logic                out_too_long_o
);
  import sbh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FIN, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    LK_FULL, LK_PAD, LK_LEN
  } load_e;

  state_e      state_q, state_d;
  load_e       kind_q, kind_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic        ovf_q, ovf_d;
  logic        dig_q, dig_d;
  logic        two_q, two_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic [31:0] out_word_q, out_word_d;
  logic [31:0] h_q [NumHashWords];
  logic [31:0] h_d [NumHashWords];
  logic [31:0] dh_q [NumHashWords];
  logic [31:0] dh_d [NumHashWords];
  logic [31:0] v_q [NumHashWords];
  logic [31:0] v_d [NumHashWords];
  logic [31:0] sum [NumHashWords];
  logic [31:0] w_q [BlockWords];
  logic [31:0] w_d [BlockWords];
  logic [31:0] stage_q, stage_d;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;
  logic [3:0]  ld_idx;
  logic [31:0] ld_word, pad_word, t_val;
  logic [63:0] bitlen_inc;
  logic        take;

  sbh_ram #(.Width(32), .Depth(BlockWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[3:0]),
    .rdata_o (ram_rdata)
  );

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign ram_we      = take && (cmd_i.op == OP_ABSORB) && !ovf_q && (fill_q[1:0] == 2'd3);
  assign ram_waddr   = fill_q[5:2];
  assign ram_wdata   = {stage_q[31:8], cmd_i.data};
  assign bitlen_inc  = bitlen_q + 64'd8;
  assign ld_idx      = cnt_q[3:0] - 4'd1;

  // Word of the partial block with the 0x80 marker after the last byte.
  always_comb begin
    case (fill_q[1:0])
      2'd0:    pad_word = 32'h8000_0000;
      2'd1:    pad_word = {stage_q[31:24], 24'h80_0000};
      2'd2:    pad_word = {stage_q[31:16], 16'h8000};
      default: pad_word = {stage_q[31:8], 8'h80};
    endcase
  end

  always_comb begin
    ld_word = 32'd0;
    case (kind_q)
      LK_FULL: ld_word = ram_rdata;
      LK_PAD: begin
        if (ld_idx < fill_q[5:2]) begin
          ld_word = ram_rdata;
        end else if (ld_idx == fill_q[5:2]) begin
          ld_word = pad_word;
        end else if (!two_q && ld_idx == 4'd14) begin
          ld_word = bitlen_q[63:32];
        end else if (!two_q && ld_idx == 4'd15) begin
          ld_word = bitlen_q[31:0];
        end
      end
      LK_LEN: begin
        if (ld_idx == 4'd14) begin
          ld_word = bitlen_q[63:32];
        end else if (ld_idx == 4'd15) begin
          ld_word = bitlen_q[31:0];
        end
      end
      default: ld_word = 32'd0;
    endcase
  end

  assign t_val = rotl5(v_q[0]) + round_f(cnt_q, v_q[1], v_q[2], v_q[3]) + v_q[4] +
                 w_q[0] + round_k(cnt_q);

  always_comb begin
    for (int i = 0; i < NumHashWords; i++) begin
      sum[i] = dh_q[i] + v_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    fill_d      = fill_q;
    bitlen_d    = bitlen_q;
    ovf_d       = ovf_q;
    dig_d       = dig_q;
    two_d       = two_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_word_d  = out_word_q;
    h_d         = h_q;
    dh_d        = dh_q;
    v_d         = v_q;
    w_d         = w_q;
    stage_d     = stage_q;

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.op)
            OP_ABSORB: begin
              if (!ovf_q) begin
                case (fill_q[1:0])
                  2'd0:    stage_d[31:24] = cmd_i.data;
                  2'd1:    stage_d[23:16] = cmd_i.data;
                  2'd2:    stage_d[15:8]  = cmd_i.data;
                  default: stage_d[7:0]   = cmd_i.data;
                endcase
                fill_d   = fill_q + 6'd1;
                bitlen_d = bitlen_inc;
                if (bitlen_inc == 64'd0) begin
                  ovf_d = 1'b1;
                end
                // Block full: fold it into the running hash.
                if (fill_q == 6'd63) begin
                  dh_d    = h_q;
                  dig_d   = 1'b0;
                  kind_d  = LK_FULL;
                  cnt_d   = 7'd0;
                  state_d = ST_LOAD;
                end
              end
            end
            OP_DIGEST: begin
              dh_d    = h_q;
              dig_d   = 1'b1;
              two_d   = (fill_q >= 6'd56);
              kind_d  = LK_PAD;
              cnt_d   = 7'd0;
              state_d = ST_LOAD;
            end
            OP_RESTART: begin
              h_d      = InitHash;
              fill_d   = 6'd0;
              bitlen_d = 64'd0;
              ovf_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        if (cnt_q != 7'd0) begin
          for (int i = 0; i < BlockWords - 1; i++) begin
            w_d[i] = w_q[i+1];
          end
          w_d[BlockWords-1] = ld_word;
        end
        if (cnt_q == 7'd16) begin
          v_d     = dh_q;
          cnt_d   = 7'd0;
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_ROUND: begin
        v_d[0] = t_val;
        v_d[1] = v_q[0];
        v_d[2] = rotl30(v_q[1]);
        v_d[3] = v_q[2];
        v_d[4] = v_q[3];
        for (int i = 0; i < BlockWords - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[BlockWords-1] = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
        if (cnt_q == 7'(NumRounds - 1)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_FIN: begin
        dh_d  = sum;
        cnt_d = 7'd0;
        if (!dig_q) begin
          h_d     = sum;
          state_d = ST_IDLE;
        end else if (two_q) begin
          two_d   = 1'b0;
          kind_d  = LK_LEN;
          state_d = ST_LOAD;
        end else begin
          out_valid_d = 1'b1;
          out_idx_d   = 3'd0;
          out_word_d  = sum[0];
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (out_idx_q == LastWordIdx) begin
            out_valid_d = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            out_idx_d  = out_idx_q + 3'd1;
            out_word_d = dh_q[out_idx_q + 3'd1];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= LK_FULL;
      fill_q      <= 6'd0;
      bitlen_q    <= 64'd0;
      ovf_q       <= 1'b0;
      dig_q       <= 1'b0;
      two_q       <= 1'b0;
      cnt_q       <= 7'd0;
      out_valid_q <= 1'b0;
      out_idx_q   <= 3'd0;
      h_q         <= InitHash;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      fill_q      <= fill_d;
      bitlen_q    <= bitlen_d;
      ovf_q       <= ovf_d;
      dig_q       <= dig_d;
      two_q       <= two_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      h_q         <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    dh_q       <= dh_d;
    v_q        <= v_d;
    w_q        <= w_d;
    stage_q    <= stage_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_word_o     = out_word_q;
  assign out_idx_o      = out_idx_q;
  assign out_too_long_o = ovf_q;

endmodule

>>> rtl/sha1_byte_stream_hasher.sv
// Top level of the SHA-1 byte stream hasher: command queue plus hash engine.
// Each input word carries an op in tuser (absorb, digest, restart) and a message byte in
// tdata. A two-entry queue decouples the input from the engine. Every 64th absorbed byte
// also starts a compression (reading the sixteen block words from the block RAM, 80 rounds
// of one round per cycle on a single round unit, adding into the hash); the engine takes no
// command while it runs, so further words wait in the queue. A digest pads a copy of the
// state and runs one compression, or two when 56 or more bytes sit in the partial block,
// then sends five result words (word 0 first) and leaves the running hash as it was. A
// restart reloads the initial hash. Unused op code 3 is dropped at the input. After the
// 64-bit bit count wraps, further bytes are ignored until restart and every digest word
// carries the too_long flag.
module sha1_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast_o,   // last_word
  output logic        m_axis_tuser_o    // too_long
);
  import sbh_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid, cmd_ready;
  logic [31:0] out_word;
  logic [2:0]  out_idx;

  sbh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_op_i      (s_axis_tuser_i),
    .s_data_i    (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sbh_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_word_o     (out_word),
    .out_idx_o      (out_idx),
    .out_too_long_o (m_axis_tuser_o)
  );

  // Pack result fields; flag the final word of the digest.
  assign m_axis_tdata_o = {5'd0, out_idx, out_word};
  assign m_axis_tlast_o = (out_idx == LastWordIdx);

endmodule

>>> rtl/sbh_checker.sv
// Port-level checker for the SHA-1 byte stream hasher, bound to the top level.
module sbh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  // Hold a stalled result word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result word changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd4)))
    else $error("tlast does not match word index four");

  // Advance the word index by one within a digest.
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tdata_o[34:32] == $past(m_axis_tdata_o[34:32]) + 3'd1))
    else $error("digest word sequence broken");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> $stable(m_axis_tuser_o))
    else $error("too_long changed within a digest");

endmodule

bind sha1_byte_stream_hasher sbh_checker u_sbh_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the SHA-1 byte stream hasher: directed table plus random words.
module tb;
  import sbh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        long_flag;
  } digest_word_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  data;
    bit          typed;
    logic [31:0] h0;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  sha1_byte_stream_hasher dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the hasher state.
  logic [7:0]  msg_block [64];
  int unsigned fill_cnt;
  logic [31:0] run_hash [5];
  logic [63:0] msg_bits;
  bit          len_wrapped;
  digest_word_t digest_q [$];
  int unsigned  fail_cnt = 0;
  bit           rx_stall_on = 1'b1;

  function automatic logic [31:0] rl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha1_fold(inout logic [31:0] h [5], input logic [7:0] blk [64]);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++) w[i] = rl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rl(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rl(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endtask

  task automatic reload_hash();
    for (int i = 0; i < 5; i++) run_hash[i] = InitHash[i];
    fill_cnt = 0;
    msg_bits = '0;
    len_wrapped = 1'b0;
  endtask

  // Advance the predictor by one accepted word; queue the digest words it causes.
  task automatic predict_word(logic [1:0] op, logic [7:0] data);
    logic [31:0] h [5];
    logic [7:0]  blk [64];
    int unsigned n;
    digest_word_t dw;
    case (op)
      OP_ABSORB: begin
        if (!len_wrapped) begin
          msg_block[fill_cnt] = data;
          fill_cnt++;
          msg_bits += 64'd8;
          if (msg_bits == 64'd0) len_wrapped = 1'b1;
          if (fill_cnt == 64) begin
            sha1_fold(run_hash, msg_block);
            fill_cnt = 0;
          end
        end
      end
      OP_RESTART: reload_hash();
      OP_DIGEST: begin
        h = run_hash;
        blk = msg_block;
        n = fill_cnt;
        blk[n] = 8'h80;
        n++;
        if (n > 56) begin
          while (n < 64) begin
            blk[n] = 8'h00;
            n++;
          end
          sha1_fold(h, blk);
          n = 0;
        end
        while (n < 56) begin
          blk[n] = 8'h00;
          n++;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
        sha1_fold(h, blk);
        for (int i = 0; i < 5; i++) begin
          dw.word = h[i];
          dw.idx = 3'(i);
          dw.last = (i == 4);
          dw.long_flag = len_wrapped;
          digest_q.push_back(dw);
        end
      end
      default: ;
    endcase
  endtask

  // Hand one word to the block, with a random gap before it.
  task automatic send_word(logic [1:0] op, logic [7:0] data);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk_i) s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    s_axis_tvalid_i <= 1'b0;
    predict_word(op, data);
  endtask

  task automatic wait_drained();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, compare each accepted word with the oldest prediction.
  initial begin
    int hold;
    digest_word_t exp_w;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h", $realtime, m_axis_tdata_o);
          fail_cnt++;
        end else begin
          exp_w = digest_q.pop_front();
          if (m_axis_tdata_o !== {5'b0, exp_w.idx, exp_w.word} ||
              m_axis_tlast_o !== exp_w.last || m_axis_tuser_o !== exp_w.long_flag) begin
            $display("%0t: digest mismatch exp idx %0d word %h last %b long %b, got %h %b %b",
                     $realtime, exp_w.idx, exp_w.word, exp_w.last, exp_w.long_flag,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
            fail_cnt++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Directed rows; h0 is typed only for the known empty and "abc" digests.
  dir_row_t dir_rows [] = '{
    '{OP_DIGEST,  8'h00, 1'b1, 32'hDA39A3EE},  // empty message after reset
    '{OP_ABSORB,  8'h61, 1'b0, 32'h0},
    '{OP_ABSORB,  8'h62, 1'b0, 32'h0},
    '{OP_ABSORB,  8'h63, 1'b0, 32'h0},
    '{OP_DIGEST,  8'hFF, 1'b1, 32'hA9993E36},  // "abc"; byte ignored
    '{OP_DIGEST,  8'h00, 1'b1, 32'hA9993E36},  // running state left as it was
    '{OpUnused,   8'hFF, 1'b0, 32'h0},         // unused op dropped
    '{OP_ABSORB,  8'hFF, 1'b0, 32'h0},
    '{OP_ABSORB,  8'h00, 1'b0, 32'h0},
    '{OP_DIGEST,  8'h5A, 1'b0, 32'h0},
    '{OP_RESTART, 8'hA5, 1'b0, 32'h0},
    '{OP_DIGEST,  8'h00, 1'b1, 32'hDA39A3EE}   // empty again after restart
  };

  initial begin
    logic [1:0] op;
    int len;
    int nq;
    reload_hash();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[r]) begin
      send_word(dir_rows[r].op, dir_rows[r].data);
      nq = digest_q.size();
      if (dir_rows[r].typed && nq >= 5 && digest_q[nq-5].word != dir_rows[r].h0) begin
        $display("%0t: predictor word 0 %h, expected %h",
                 $realtime, digest_q[nq-5].word, dir_rows[r].h0);
        fail_cnt++;
      end
    end
    // Digests at the padding edges: 55, 56 and 64 bytes in the message.
    for (int j = 0; j < 3; j++) begin
      send_word(OP_RESTART, 8'h00);
      len = (j == 0) ? 55 : (j == 1) ? 56 : 64;
      repeat (len) send_word(OP_ABSORB, 8'(($urandom_range(0, 1)) ? 8'hFF : 8'h00));
      send_word(OP_DIGEST, 8'h00);
    end
    // Hold off until every digest word is back.
    wait_drained();
    // Random messages: mostly absorbs with a digest now and then.
    for (int i = 0; i < 150; i++) begin
      case ($urandom_range(0, 19))
        0, 1: op = OP_DIGEST;
        2:    op = OP_RESTART;
        3:    op = OpUnused;
        default: op = OP_ABSORB;
      endcase
      if (i == 75) begin
        rx_stall_on = 1'b0;
      end
      send_word(op, 8'($urandom_range(0, 255)));
    end
    send_word(OP_DIGEST, 8'h00);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
